FILE: hw/rtl/kexinit_name_list_walker_core_assert.svh
// Assertion macros shared by the name-list walker RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef KEXINIT_NAME_LIST_WALKER_CORE_ASSERT_SVH
`define KEXINIT_NAME_LIST_WALKER_CORE_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define KWALK_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after the trigger.
`define KWALK_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: hw/rtl/kwalk_pkg.sv
// Package for the name-list walker: item and result types, phase and status codes.
// No dependencies.
`default_nettype none

package kwalk_pkg;

  localparam int unsigned LIST_COUNT = 10;
  localparam int unsigned LEN_BYTES  = 4;

  localparam logic [1:0] PH_LENGTH = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_FLAG   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  localparam logic [1:0] LEN_LAST_IDX = 2'(LEN_BYTES - 1);
  localparam logic [4:0] LIST_LIMIT   = 5'(LIST_COUNT);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        length_valid;
    logic [3:0]  list_number;
    logic [31:0] list_length;
    logic [7:0]  first_kex_follows;
    logic        payload_end;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kwalk_in_stage.sv
// Input register of the name-list walker: holds one accepted item.
// Depends on kwalk_pkg.
`default_nettype none

module kwalk_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_last_byte,
  output logic                 stg_valid,
  output kwalk_pkg::item_t     stg_item,
  input  wire logic            stg_take
);

  logic             valid_r;
  logic             valid_nxt;
  kwalk_pkg::item_t item_r;

  // Refill whenever the held item leaves or the stage is empty.
  assign in_ready  = !valid_r || stg_take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (stg_take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.data_byte <= in_data_byte;
      item_r.last_byte <= in_last_byte;
    end
  end

  assign stg_valid = valid_r;
  assign stg_item  = item_r;

endmodule

`default_nettype wire

FILE: hw/rtl/kwalk_walker.sv
// Walker state and step logic: one byte in, one result out per step.
// Depends on kwalk_pkg and kexinit_name_list_walker_core_assert.svh.
`default_nettype none
`include "kexinit_name_list_walker_core_assert.svh"

module kwalk_walker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire kwalk_pkg::item_t  item,
  output kwalk_pkg::result_t     result
);

  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  list_cnt_r, list_cnt_nxt;
  logic [1:0]  len_cnt_r, len_cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [7:0]  flag_r, flag_nxt;

  logic [31:0] acc_shift;
  logic [31:0] rem_dec;
  logic        list_last;
  logic        len_valid;
  logic [1:0]  status;

  assign acc_shift = {acc_r[23:0], item.data_byte};
  assign rem_dec   = rem_r - 32'd1;
  assign list_last = ({1'b0, list_cnt_r} + 5'd1) >= kwalk_pkg::LIST_LIMIT;

  always_comb begin
    phase_nxt    = phase_r;
    list_cnt_nxt = list_cnt_r;
    len_cnt_nxt  = len_cnt_r;
    acc_nxt      = acc_r;
    rem_nxt      = rem_r;
    flag_nxt     = flag_r;
    len_valid    = 1'b0;
    unique case (phase_r)
      kwalk_pkg::PH_LENGTH: begin
        acc_nxt = acc_shift;
        if (len_cnt_r == kwalk_pkg::LEN_LAST_IDX) begin
          len_cnt_nxt = 2'd0;
          len_valid   = 1'b1;
          rem_nxt     = acc_shift;
          acc_nxt     = 32'd0;
          if (acc_shift == 32'd0) begin
            // Empty list: go straight to the next one, or to the flag byte after the last list.
            if (list_last) begin
              phase_nxt = kwalk_pkg::PH_FLAG;
            end else begin
              list_cnt_nxt = list_cnt_r + 4'd1;
            end
          end else begin
            phase_nxt = kwalk_pkg::PH_BODY;
          end
        end else begin
          len_cnt_nxt = len_cnt_r + 2'd1;
        end
      end
      kwalk_pkg::PH_BODY: begin
        rem_nxt = rem_dec;
        if (rem_dec == 32'd0) begin
          if (list_last) begin
            phase_nxt = kwalk_pkg::PH_FLAG;
          end else begin
            list_cnt_nxt = list_cnt_r + 4'd1;
            phase_nxt    = kwalk_pkg::PH_LENGTH;
          end
        end
      end
      kwalk_pkg::PH_FLAG: begin
        flag_nxt  = item.data_byte;
        phase_nxt = kwalk_pkg::PH_DONE;
      end
      default: begin
        // Complete: drop further bytes until the final one.
      end
    endcase
  end

  always_comb begin
    if (phase_nxt == kwalk_pkg::PH_DONE) begin
      status = kwalk_pkg::ST_DONE;
    end else if (item.last_byte) begin
      status = kwalk_pkg::ST_TRUNC;
    end else begin
      status = kwalk_pkg::ST_BUSY;
    end
  end

  assign result.status            = status;
  assign result.length_valid      = len_valid;
  assign result.list_number       = len_valid ? list_cnt_r : 4'd0;
  assign result.list_length       = len_valid ? acc_shift : 32'd0;
  assign result.first_kex_follows = (status == kwalk_pkg::ST_DONE) ? flag_nxt : 8'd0;
  assign result.payload_end       = item.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      phase_r    <= kwalk_pkg::PH_LENGTH;
      list_cnt_r <= 4'd0;
      len_cnt_r  <= 2'd0;
      acc_r      <= 32'd0;
      rem_r      <= 32'd0;
      flag_r     <= 8'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      list_cnt_r <= list_cnt_nxt;
      len_cnt_r  <= len_cnt_nxt;
      acc_r      <= acc_nxt;
      rem_r      <= rem_nxt;
      flag_r     <= flag_nxt;
    end
  end

  `KWALK_ASSERT_ALWAYS(a_list_in_range, ({1'b0, list_cnt_r} < kwalk_pkg::LIST_LIMIT),
                       "list index out of range")
  `KWALK_ASSERT_ALWAYS(a_len_cnt_idle,
                       ((phase_r == kwalk_pkg::PH_LENGTH) || (len_cnt_r == 2'd0)),
                       "length count left over outside length phase")
  `KWALK_ASSERT_ALWAYS(a_body_nonzero,
                       ((phase_r != kwalk_pkg::PH_BODY) || (rem_r != 32'd0)),
                       "body phase with nothing remaining")
  `KWALK_ASSERT_NEXT(a_clear_on_last, (step && item.last_byte),
                     ((phase_r == kwalk_pkg::PH_LENGTH) && (list_cnt_r == 4'd0) &&
                      (acc_r == 32'd0)),
                     "state not cleared after final byte")

endmodule

`default_nettype wire

FILE: hw/rtl/kexinit_name_list_walker_core.sv
// Path: a byte accepted into the input register moves to the result register on an
//   advance, which waits while a held result is not taken; its result is then offered.
// Throughput is one byte per cycle while out_ready is high; the input register
//   refills once while a finished result waits on out_ready.
// Reset (rst_n low, synchronous) empties both registers and returns the walk to
//   the first length field of the first name-list; a final byte also returns the walk there.
`default_nettype none

module kexinit_name_list_walker_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_length_valid,
  output logic [3:0]       out_list_number,
  output logic [31:0]      out_list_length,
  output logic [7:0]       out_first_kex_follows,
  output logic             out_payload_end
);

  logic               stg_valid;
  kwalk_pkg::item_t   stg_item;
  logic               advance;
  kwalk_pkg::result_t step_res;

  logic               out_valid_r;
  logic               out_valid_nxt;
  kwalk_pkg::result_t res_r;

  // Advance the held byte whenever the result register is free or draining.
  assign advance = stg_valid && (!out_valid_r || out_ready);

  kwalk_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .stg_valid    (stg_valid),
    .stg_item     (stg_item),
    .stg_take     (advance)
  );

  // Walker state moves only on an advance; its result is combinational.
  kwalk_walker u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (stg_item),
    .result (step_res)
  );

  // Result register: hold while the consumer stalls, load on advance.
  assign out_valid_nxt = advance ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = res_r.status;
  assign out_length_valid      = res_r.length_valid;
  assign out_list_number       = res_r.list_number;
  assign out_list_length       = res_r.list_length;
  assign out_first_kex_follows = res_r.first_kex_follows;
  assign out_payload_end       = res_r.payload_end;

endmodule

`default_nettype wire
